// ----- design/sstg_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the stereo square tone generator.
package sstg_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int RATE_W   = 18;
    localparam int FREQ_W   = 8;
    localparam int PERIOD_W = 10;
    localparam int SAMPLE_W = 13;
    localparam int VOL_W    = 4;
    localparam int SUM_W    = SAMPLE_W + CH_IDX_W;

    localparam logic [RATE_W-1:0]   RATE_RESET = RATE_W'(44100);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // period = floor(rate * freq / 62500), i.e. rate * freq * 64 / 4 MHz.
    // The reciprocal is ceil(2^42 / 62500); exact for products below 2^26.
    localparam int PROD_W       = RATE_W + FREQ_W;
    localparam int RECIP_W      = 27;
    localparam int RECIP_SHIFT  = 42;
    localparam int QUOT_W       = PROD_W + RECIP_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(70368745);

    // op codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LEFT  = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;

    // register index within a channel
    localparam logic [1:0] REG_FREQ    = 2'd0;
    localparam logic [1:0] REG_FREQ_HI = 2'd1;
    localparam logic [1:0] REG_CTRL    = 2'd2;

    // control register bits
    localparam int LEFT_EN_BIT  = 6;
    localparam int RIGHT_EN_BIT = 5;

    typedef struct packed {
        logic                valid;
        logic [CH_IDX_W-1:0] ch;
        logic [FREQ_W-1:0]   freq;
    } period_req_t;

    typedef struct packed {
        logic                valid;
        logic [CH_IDX_W-1:0] ch;
        logic [PERIOD_W-1:0] period;
    } period_upd_t;

endpackage

// ----- design/sstg_period.sv -----
`timescale 1ns / 1ps
// Two-step period calculation: rate times frequency byte, then divide by 62500.
module sstg_period
    import sstg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RATE_W-1:0] sample_rate,
    input  period_req_t       req,
    output period_upd_t       upd,
    output logic              busy
);

    logic                      a_valid_reg;
    logic [CH_IDX_W-1:0]       a_ch_reg;
    logic [PROD_W-1:0]         a_prod_reg;
    logic [PROD_W-1:0]         a_prod_next;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [QUOT_W-1:0]         quot;

    assign a_prod_next = PROD_W'(sample_rate) * PROD_W'(req.freq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            a_ch_reg   <= req.ch;
            a_prod_reg <= a_prod_next;
        end
    end

    // multiply by the reciprocal; the top bits are the exact quotient
    assign scaled = (PROD_W+RECIP_W)'(a_prod_reg) * (PROD_W+RECIP_W)'(RECIP);
    assign quot   = scaled[PROD_W+RECIP_W-1:RECIP_SHIFT];

    always_comb
    begin
        upd.valid = a_valid_reg;
        upd.ch    = a_ch_reg;
        if (quot > QUOT_W'(PERIOD_MAX))
        begin
            upd.period = PERIOD_MAX;
        end
        else
        begin
            upd.period = quot[PERIOD_W-1:0];
        end
    end

    assign busy = a_valid_reg;

endmodule

// ----- design/stereo_square_tone_generator.sv -----
`timescale 1ns / 1ps
// A tick's sample goes through the input register and the result register to m_tdata.
// One item per clock unless m_tready stalls a tick; a write to register 0 or 1 holds off
// the next item while the period multiplier (rate x byte, then x reciprocal) settles.
// Writes to other registers run back to back, and so do ticks while the output drains.
// Reset (rst_n low, async): registers, periods and phases clear to zero,
// sample_rate returns to 44100, both streams go empty.
module stereo_square_tone_generator
    import sstg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [RATE_W-1:0] cfg_wr_data,    // sample_rate
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,        // channel_select, reg_index[1:0], write_data[7:0]
    input  logic [1:0]        s_tuser,        // op[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata         // sample[12:0]
);

    logic [RATE_W-1:0]   sample_rate_reg;

    logic                s1_valid_reg;
    logic [1:0]          s1_op_reg;
    logic                s1_ch_reg;
    logic [1:0]          s1_ri_reg;
    logic [FREQ_W-1:0]   s1_data_reg;

    logic [FREQ_W-1:0]   freq_reg   [NUM_CHANNELS];
    logic [7:0]          ctrl_reg   [NUM_CHANNELS];
    logic [PERIOD_W-1:0] period_reg [NUM_CHANNELS];
    logic [PERIOD_W-1:0] left_phase_reg  [NUM_CHANNELS];
    logic [PERIOD_W-1:0] right_phase_reg [NUM_CHANNELS];

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;

    logic                is_write;
    logic                is_tick;
    logic                side_right;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_ok;
    logic                period_write;
    logic                out_free;
    logic                s1_adv;
    logic                busy;

    logic                ch_en     [NUM_CHANNELS];
    logic [PERIOD_W-1:0] phase_adv [NUM_CHANNELS];
    logic [SUM_W-1:0]    sum;

    period_req_t         preq;
    period_upd_t         pupd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            sample_rate_reg <= cfg_wr_data;
        end
    end

    // item decode in the input register
    assign is_write     = (s1_op_reg == OP_WRITE);
    assign is_tick      = (s1_op_reg == OP_LEFT) || (s1_op_reg == OP_RIGHT);
    assign side_right   = (s1_op_reg == OP_RIGHT);
    assign ch_idx       = CH_IDX_W'(s1_ch_reg);
    assign ch_ok        = (int'(s1_ch_reg) < NUM_CHANNELS);
    assign period_write = is_write && ch_ok &&
                          ((s1_ri_reg == REG_FREQ) || (s1_ri_reg == REG_FREQ_HI));

    assign out_free = !m_valid_reg || m_tready;
    // nothing leaves the input register while a new period is on its way
    assign s1_adv   = s1_valid_reg && !busy && (!is_tick || out_free);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg   <= s_tuser;
            s1_ch_reg   <= s_tdata[0];
            s1_ri_reg   <= s_tdata[2:1];
            s1_data_reg <= s_tdata[10:3];
        end
    end

    // per-channel square wave for the ticked side
    always_comb
    begin
        logic [PERIOD_W-1:0] phase;
        logic [PERIOD_W:0]   inc;
        phase = '0;
        inc   = '0;
        sum   = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            ch_en[c] = side_right ? ctrl_reg[c][RIGHT_EN_BIT] : ctrl_reg[c][LEFT_EN_BIT];
            phase    = side_right ? right_phase_reg[c] : left_phase_reg[c];
            inc      = {1'b0, phase} + 1'b1;
            if (inc >= {1'b0, period_reg[c]})
            begin
                phase_adv[c] = '0;
            end
            else
            begin
                phase_adv[c] = inc[PERIOD_W-1:0];
            end
            if (ch_en[c] && (phase <= (period_reg[c] >> 1)))
            begin
                sum = sum + SUM_W'({ctrl_reg[c][VOL_W-1:0], 8'h00});
            end
        end
        if (sum > SUM_W'(SAMPLE_MAX))
        begin
            sample_next = SAMPLE_MAX;
        end
        else
        begin
            sample_next = sum[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        preq.valid = s1_adv && period_write;
        preq.ch    = ch_idx;
        preq.freq  = (s1_ri_reg == REG_FREQ) ? s1_data_reg : freq_reg[ch_idx];
    end

    sstg_period u_period (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_rate (sample_rate_reg),
        .req         (preq),
        .upd         (pupd),
        .busy        (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                freq_reg[c]        <= '0;
                ctrl_reg[c]        <= '0;
                period_reg[c]      <= '0;
                left_phase_reg[c]  <= '0;
                right_phase_reg[c] <= '0;
            end
        end
        else
        begin
            if (pupd.valid)
            begin
                period_reg[pupd.ch] <= pupd.period;
            end
            if (s1_adv && is_write && ch_ok)
            begin
                if (s1_ri_reg == REG_FREQ)
                begin
                    freq_reg[ch_idx] <= s1_data_reg;
                end
                if (s1_ri_reg == REG_CTRL)
                begin
                    ctrl_reg[ch_idx] <= s1_data_reg;
                end
                if (period_write)
                begin
                    left_phase_reg[ch_idx]  <= '0;
                    right_phase_reg[ch_idx] <= '0;
                end
            end
            if (s1_adv && is_tick)
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (ch_en[c])
                    begin
                        if (side_right)
                        begin
                            right_phase_reg[c] <= phase_adv[c];
                        end
                        else
                        begin
                            left_phase_reg[c] <= phase_adv[c];
                        end
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_adv && is_tick)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && is_tick)
        begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-SAMPLE_W){1'b0}}, sample_reg};

`ifndef NO_ASSERTIONS
    // a period-changing write must raise busy and hold off the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && period_write) |=> (busy && !s1_adv))
        else $error("period update did not stall the input register");

    // channel 0 phases stay inside the current period (zero when the period is zero)
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_phase_reg[0] < period_reg[0]) ||
        ((period_reg[0] == '0) && (left_phase_reg[0] == '0)))
        else $error("left phase of channel 0 outside its period");

    assert property (@(posedge clk) disable iff (!rst_n)
        (right_phase_reg[0] < period_reg[0]) ||
        ((period_reg[0] == '0) && (right_phase_reg[0] == '0)))
        else $error("right phase of channel 0 outside its period");
`endif

endmodule

// ----- bench/stereo_square_tone_generator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the stereo square tone generator: random bursts in, stalls out.
module stereo_square_tone_generator_tb
    import sstg_pkg::*;
();

    localparam logic [1:0] OP_NONE    = 2'd3;   // unused op, block ignores it
    localparam logic [1:0] REG_SPARE  = 2'd3;   // ignored by the block, kept only in the scoreboard
    localparam int ITEMS_PER_PHASE    = 185;
    localparam int NUM_PHASES         = 6;
    localparam int SETTLE_CYCLES      = 8;
    localparam int TIMEOUT_NS         = 5_000_000;

    // Tracks register/phase state and the samples owed by the block.
    class tone_scoreboard;
        logic [RATE_W-1:0]   rate;
        logic [7:0]          regs [NUM_CHANNELS][4];
        int unsigned         period [NUM_CHANNELS];
        int unsigned         left_ph [NUM_CHANNELS];
        int unsigned         right_ph [NUM_CHANNELS];
        logic [SAMPLE_W-1:0] samples_due [$];
        int                  errors;

        function new();
            rate = RATE_RESET;
            errors = 0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                for (int r = 0; r < 4; r++)
                    regs[c][r] = 8'h00;
                period[c] = 0;
                left_ph[c] = 0;
                right_ph[c] = 0;
            end
        endfunction

        function void set_rate(logic [RATE_W-1:0] value);
            rate = value;
        endfunction

        function logic [SAMPLE_W-1:0] tick(bit right);
            int unsigned sum;
            int unsigned ph;
            logic [7:0]  ctrl;
            logic        en;
            sum = 0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                ctrl = regs[c][REG_CTRL];
                en = right ? ctrl[RIGHT_EN_BIT] : ctrl[LEFT_EN_BIT];
                if (en)
                begin
                    ph = right ? right_ph[c] : left_ph[c];
                    if (ph <= period[c] / 2)
                        sum += int'(ctrl[VOL_W-1:0]) << 8;
                    ph++;
                    // zero period pins the phase at 0
                    if (ph >= period[c])
                        ph = 0;
                    if (right)
                        right_ph[c] = ph;
                    else
                        left_ph[c] = ph;
                end
            end
            if (sum > int'(SAMPLE_MAX))
                sum = int'(SAMPLE_MAX);
            return sum[SAMPLE_W-1:0];
        endfunction

        function void note_item(logic [1:0] op, logic ch, logic [1:0] ri, logic [7:0] data);
            longint unsigned p;
            case (op)
                OP_WRITE:
                begin
                    if (int'(ch) < NUM_CHANNELS)
                    begin
                        regs[ch][ri] = data;
                        if (ri == REG_FREQ || ri == REG_FREQ_HI)
                        begin
                            p = (64'(rate) * 64'(regs[ch][REG_FREQ]) * 64) / 64'd4000000;
                            if (p > 64'(PERIOD_MAX))
                                p = 64'(PERIOD_MAX);
                            period[ch] = int'(p);
                            left_ph[ch] = 0;
                            right_ph[ch] = 0;
                        end
                    end
                end
                OP_LEFT:  samples_due.push_back(tick(1'b0));
                OP_RIGHT: samples_due.push_back(tick(1'b1));
                default: ;
            endcase
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (samples_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample %0d with nothing pending", got);
                return;
            end
            want = samples_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("sample mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [RATE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata     = '0;
    logic [1:0]        s_tuser     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [15:0]       m_tdata;

    tone_scoreboard sb;
    int             burst_left = 0;

    stereo_square_tone_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // Output side: the stall pattern switches at random between always, half and rarely ready.
    initial
    begin
        int hold;
        int mode;
        hold = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_sample(m_tdata[SAMPLE_W-1:0]);
            if (hold == 0)
            begin
                mode = $urandom_range(0, 2);
                hold = $urandom_range(10, 80);
            end
            hold--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // One input transfer; opens a new burst after a random gap when the last one ran out.
    task automatic send_item(input logic [1:0] op, input logic ch, input logic [1:0] ri,
                             input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, data, ri, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, ch, ri, data);
    endtask

    // Hold off input until every pending sample is out, then let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.samples_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_rate(value);
    endtask

    initial
    begin
        logic [RATE_W-1:0] rates [NUM_PHASES];
        logic [1:0]        op;
        logic              ch;
        logic [1:0]        ri;
        logic [7:0]        data;
        int                r;

        sb = new();
        rates[0] = RATE_RESET;
        rates[1] = RATE_W'(1);
        rates[2] = RATE_W'(192000);
        rates[3] = '1;                      // above range: large frequency bytes saturate periods
        rates[4] = RATE_W'($urandom_range(1, 192000));
        rates[5] = RATE_W'(8000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: nothing enabled, zero period, full sum, wrap, spare reg, op 3
        send_item(OP_LEFT, 1'b0, 2'd0, 8'h00);
        send_item(OP_WRITE, 1'b0, REG_CTRL, 8'h4f);
        send_item(OP_LEFT, 1'b1, 2'd3, 8'hff);
        send_item(OP_LEFT, 1'b0, 2'd1, 8'h00);
        send_item(OP_WRITE, 1'b1, REG_CTRL, 8'h7f);
        send_item(OP_LEFT, 1'b0, 2'd0, 8'h00);
        send_item(OP_RIGHT, 1'b0, 2'd0, 8'h00);
        send_item(OP_WRITE, 1'b0, REG_FREQ, 8'hff);
        send_item(OP_WRITE, 1'b1, REG_FREQ, 8'h05);
        for (int i = 0; i < 4; i++)
        begin
            send_item(OP_LEFT, 1'b0, 2'd0, 8'h00);
            send_item(OP_RIGHT, 1'b1, 2'd2, 8'h80);
        end
        send_item(OP_WRITE, 1'b1, REG_SPARE, 8'haa);
        send_item(OP_WRITE, 1'b1, REG_FREQ_HI, 8'h55);
        send_item(OP_LEFT, 1'b0, 2'd0, 8'h00);
        send_item(OP_NONE, 1'b1, 2'd3, 8'hff);
        send_item(OP_WRITE, 1'b0, REG_CTRL, 8'h20);
        send_item(OP_WRITE, 1'b1, REG_CTRL, 8'h00);
        send_item(OP_RIGHT, 1'b0, 2'd0, 8'h00);
        send_item(OP_LEFT, 1'b0, 2'd0, 8'h00);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                write_rate(rates[phase]);
                send_item(OP_WRITE, 1'b0, REG_FREQ, 8'hff);
                send_item(OP_WRITE, 1'b1, REG_FREQ, 8'($urandom_range(1, 40)));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r    = $urandom_range(0, 99);
                ch   = 1'($urandom_range(0, 1));
                ri   = 2'($urandom_range(0, 3));
                data = 8'($urandom_range(0, 255));
                if (r < 3)
                    op = OP_NONE;
                else if (r < 20)
                begin
                    op = OP_WRITE;
                    if (ri == REG_FREQ)
                    begin
                        // bias toward short periods that wrap often and long ones that clip at high rates
                        case ($urandom_range(0, 2))
                            0:       data = 8'($urandom_range(1, 40));
                            1:       data = 8'($urandom_range(200, 255));
                            default: ;
                        endcase
                    end
                    else if (ri == REG_CTRL && $urandom_range(0, 1) == 1)
                        data = data | 8'h60;
                end
                else
                    op = ($urandom_range(0, 1) == 1) ? OP_RIGHT : OP_LEFT;
                send_item(op, ch, ri, data);
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
            end
        end

        drain_results();
        if (sb.errors == 0 && sb.samples_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
